/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property check with asynchronous active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that is also evaluated during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/sqllex_pkg.sv */
// Types, character codes and classifiers for the SQL literal tokenizer.
`timescale 1ns / 1ps

package sqllex_pkg;

  localparam int unsigned MaxTokenLength = 4096;
  localparam int unsigned LenW = 13;
  localparam int unsigned KindW = 4;

  // Scan mode of the open candidate
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SIGN   = 3'd1,
    MODE_NUM    = 3'd2,
    MODE_PREFIX = 3'd3,
    MODE_STR    = 3'd4,
    MODE_BITS   = 3'd5,
    MODE_HEX    = 3'd6
  } mode_e;

  // Literal kind codes
  typedef enum logic [KindW-1:0] {
    KIND_UINT   = 4'd0,
    KIND_SINT   = 4'd1,
    KIND_UDEC   = 4'd2,
    KIND_SDEC   = 4'd3,
    KIND_APPROX = 4'd4,
    KIND_CHAR   = 4'd5,
    KIND_NATL   = 4'd6,
    KIND_BIT    = 4'd7,
    KIND_HEX    = 4'd8
  } kind_e;

  // Character codes
  localparam logic [7:0] ChPeriod = 8'h2E;
  localparam logic [7:0] ChExpE   = 8'h45;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChNatl   = 8'h4E;
  localparam logic [7:0] ChBit    = 8'h42;
  localparam logic [7:0] ChHex    = 8'h58;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= ChLowA && c <= ChLowF) || (c >= ChUpA && c <= ChUpF);
  endfunction

  // Characters that close a numeric token
  function automatic logic is_num_term(input logic [7:0] c);
    return is_space(c) || (c == ChComma) || (c == ChRParen) || (c == ChLParen) ||
           (c == ChSemi);
  endfunction

  function automatic kind_e num_kind(input logic sgn, input logic dec, input logic expo);
    kind_e k;
    if (expo) begin
      k = KIND_APPROX;
    end else if (dec) begin
      k = sgn ? KIND_SDEC : KIND_UDEC;
    end else begin
      k = sgn ? KIND_SINT : KIND_UINT;
    end
    return k;
  endfunction

endpackage

/* hw/rtl/sql_literal_tokenizer_top.sv */
// SQL literal tokenizer: one character per cycle in, at most one result per candidate out.
//
//   channel  dir  tdata                      tuser   tlast
//   s_axis   in   ch[7:0]                    first   last
//   m_axis   out  kind, start_offset, length  found   -
//
// Takes one character per cycle; the scan state and the result register are
// updated in the same cycle the request is accepted, so the only limit is the
// single output register: input stalls only while a result waits and
// m_axis_tready_i is low. A decided candidate leaves one result in the cycle after
// the deciding character. Reset leaves the block waiting for a first character.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sql_literal_tokenizer_top #(
  parameter int unsigned MAX_TOKEN_LENGTH = sqllex_pkg::MaxTokenLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tuser_i,   // [0] first
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [3:0] kind, [4] start_offset, [17:5] token_length
  output logic        m_axis_tuser_o    // [0] found
);

  localparam int unsigned CntW = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TOKEN_LENGTH);
  localparam int unsigned DataW = sqllex_pkg::KindW + 1 + sqllex_pkg::LenW;

  // Scan state
  sqllex_pkg::mode_e mode_q, mode_d;
  logic            sign_q, sign_d;
  logic            dec_q, dec_d;
  logic            exp_q, exp_d;
  logic [7:0]      prev_q, prev_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            decided_q, decided_d;
  logic            prefix_q, prefix_d;

  // Result register
  logic              m_valid_q, m_valid_d;
  logic              m_found_q, m_found_d;
  logic [DataW-1:0]  m_data_q, m_data_d;

  // Decision of the current request
  logic              emit;
  logic              ok;
  sqllex_pkg::kind_e kind;

  // Base state for the numeric path and path selects
  logic            run_num, run_str, run_radix;
  logic            b_sign, b_dec, b_exp;
  logic [7:0]      b_prev;
  logic [CntW-1:0] b_cnt;
  logic            n_dec, n_exp, num_bad, radix_ok;

  logic [7:0] ch;
  logic       first, last, s_fire;

  assign ch    = s_axis_tdata_i;
  assign first = s_axis_tuser_i;
  assign last  = s_axis_tlast_i;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Next scan state and decision for the incoming character
  always_comb begin
    mode_d    = mode_q;
    sign_d    = sign_q;
    dec_d     = dec_q;
    exp_d     = exp_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    decided_d = decided_q;
    prefix_d  = prefix_q;
    emit      = 1'b0;
    ok        = 1'b0;
    kind      = sqllex_pkg::KIND_UINT;
    run_num   = 1'b0;
    run_str   = 1'b0;
    run_radix = 1'b0;
    b_sign    = sign_q;
    b_dec     = dec_q;
    b_exp     = exp_q;
    b_prev    = prev_q;
    b_cnt     = cnt_q;
    n_dec     = 1'b0;
    n_exp     = 1'b0;
    num_bad   = 1'b0;
    radix_ok  = 1'b0;

    // Open a new candidate or continue the undecided one
    if (first) begin
      mode_d    = sqllex_pkg::MODE_IDLE;
      sign_d    = 1'b0;
      dec_d     = 1'b0;
      exp_d     = 1'b0;
      prev_d    = '0;
      cnt_d     = '0;
      prefix_d  = 1'b0;
      decided_d = 1'b0;
      b_sign    = 1'b0;
      b_dec     = 1'b0;
      b_exp     = 1'b0;
      b_prev    = '0;
      b_cnt     = '0;
      if (ch == sqllex_pkg::ChPlus || ch == sqllex_pkg::ChMinus) begin
        if (last) begin
          emit = 1'b1;
        end else begin
          sign_d = 1'b1;
          cnt_d  = CntW'(1);
          prev_d = ch;
          mode_d = sqllex_pkg::MODE_SIGN;
        end
      end else if (sqllex_pkg::is_digit(ch)) begin
        run_num = 1'b1;
      end else if (ch == sqllex_pkg::ChQuote) begin
        mode_d = sqllex_pkg::MODE_STR;
        cnt_d  = CntW'(1);
        prev_d = ch;
        emit   = last;
      end else if (ch == sqllex_pkg::ChNatl || ch == sqllex_pkg::ChBit ||
                   ch == sqllex_pkg::ChHex) begin
        if (last) begin
          emit = 1'b1;
        end else begin
          mode_d = sqllex_pkg::MODE_PREFIX;
          prev_d = ch;
        end
      end else begin
        emit = 1'b1;
      end
    end else if (!decided_q) begin
      unique case (mode_q)
        sqllex_pkg::MODE_SIGN: begin
          if (sqllex_pkg::is_digit(ch)) begin
            run_num = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
        sqllex_pkg::MODE_NUM: run_num = 1'b1;
        sqllex_pkg::MODE_PREFIX: begin
          if (ch != sqllex_pkg::ChQuote) begin
            emit = 1'b1;
          end else begin
            prefix_d = 1'b1;
            cnt_d    = CntW'(1);
            if (prev_q == sqllex_pkg::ChNatl) begin
              mode_d = sqllex_pkg::MODE_STR;
            end else if (prev_q == sqllex_pkg::ChBit) begin
              mode_d = sqllex_pkg::MODE_BITS;
            end else begin
              mode_d = sqllex_pkg::MODE_HEX;
            end
            prev_d = ch;
            emit   = last;
          end
        end
        sqllex_pkg::MODE_STR: run_str = 1'b1;
        sqllex_pkg::MODE_BITS, sqllex_pkg::MODE_HEX: run_radix = 1'b1;
        default: emit = 1'b1;
      endcase
    end

    // Numeric token: digits, one period, one E after a digit, sign after E
    if (run_num) begin
      mode_d = sqllex_pkg::MODE_NUM;
      if (sqllex_pkg::is_num_term(ch)) begin
        emit = 1'b1;
        ok   = !(b_prev == sqllex_pkg::ChPeriod) &&
               !(b_exp && !sqllex_pkg::is_digit(b_prev));
        kind = sqllex_pkg::num_kind(b_sign, b_dec, b_exp);
      end else begin
        n_dec   = b_dec || (ch == sqllex_pkg::ChPeriod);
        n_exp   = b_exp || (ch == sqllex_pkg::ChExpE);
        num_bad = ((ch == sqllex_pkg::ChPeriod) && b_dec) ||
                  ((ch == sqllex_pkg::ChExpE) && (b_exp || !sqllex_pkg::is_digit(b_prev))) ||
                  ((ch == sqllex_pkg::ChPlus || ch == sqllex_pkg::ChMinus) && !b_exp) ||
                  (!sqllex_pkg::is_digit(ch) && ch != sqllex_pkg::ChPeriod &&
                   ch != sqllex_pkg::ChExpE && ch != sqllex_pkg::ChPlus &&
                   ch != sqllex_pkg::ChMinus);
        if (num_bad || b_cnt >= CntMax) begin
          emit = 1'b1;
        end else begin
          cnt_d  = b_cnt + CntW'(1);
          prev_d = ch;
          dec_d  = n_dec;
          exp_d  = n_exp;
          sign_d = b_sign;
          if (last) begin
            emit = 1'b1;
            ok   = !(ch == sqllex_pkg::ChPeriod) && !(n_exp && !sqllex_pkg::is_digit(ch));
            kind = sqllex_pkg::num_kind(b_sign, n_dec, n_exp);
          end
        end
      end
    end

    // Quoted string: closes at a quote not escaped by a backslash
    if (run_str) begin
      if (cnt_q >= CntMax) begin
        emit = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
        if (ch == sqllex_pkg::ChQuote && prev_q != sqllex_pkg::ChBslash) begin
          emit = 1'b1;
          ok   = 1'b1;
          kind = prefix_q ? sqllex_pkg::KIND_NATL : sqllex_pkg::KIND_CHAR;
        end else begin
          prev_d = ch;
          emit   = last;
        end
      end
    end

    // Bit or hex string: closing quote before white space or buffer end
    if (run_radix) begin
      kind = (mode_q == sqllex_pkg::MODE_BITS) ? sqllex_pkg::KIND_BIT : sqllex_pkg::KIND_HEX;
      if (sqllex_pkg::is_space(ch)) begin
        emit = 1'b1;
        ok   = (prev_q == sqllex_pkg::ChQuote) && (cnt_q > CntW'(1));
      end else begin
        if (mode_q == sqllex_pkg::MODE_BITS) begin
          radix_ok = (ch == sqllex_pkg::ChZero) || (ch == sqllex_pkg::ChOne) ||
                     (ch == sqllex_pkg::ChQuote);
        end else begin
          radix_ok = sqllex_pkg::is_hex(ch) || (ch == sqllex_pkg::ChQuote);
        end
        if (!radix_ok || cnt_q >= CntMax) begin
          emit = 1'b1;
        end else begin
          cnt_d  = cnt_q + CntW'(1);
          prev_d = ch;
          if (last) begin
            emit = 1'b1;
            ok   = (ch == sqllex_pkg::ChQuote) && (cnt_q != '0);
          end
        end
      end
    end

    // A decision closes the candidate
    if (emit) begin
      decided_d = 1'b1;
      mode_d    = sqllex_pkg::MODE_IDLE;
    end
  end

  // Result register contents
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_found_d = m_found_q;
    m_data_d  = m_data_q;
    if (s_fire && emit) begin
      m_valid_d = 1'b1;
      m_found_d = ok;
      if (ok) begin
        m_data_d = {sqllex_pkg::LenW'(cnt_d), prefix_d, kind};
      end else begin
        m_data_d = '0;
      end
    end
  end

  // Advance scan state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sqllex_pkg::MODE_IDLE;
      sign_q    <= 1'b0;
      dec_q     <= 1'b0;
      exp_q     <= 1'b0;
      prev_q    <= '0;
      cnt_q     <= '0;
      decided_q <= 1'b1;
      prefix_q  <= 1'b0;
    end else if (s_fire) begin
      mode_q    <= mode_d;
      sign_q    <= sign_d;
      dec_q     <= dec_d;
      exp_q     <= exp_d;
      prev_q    <= prev_d;
      cnt_q     <= cnt_d;
      decided_q <= decided_d;
      prefix_q  <= prefix_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_found_q <= m_found_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_found_q;
  assign m_axis_tdata_o  = {(24 - DataW)'(0), m_data_q};

  // Checks
  `ASSERT_CLK(a_miss_zero, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0, "miss result carries data")
  `ASSERT_CLK(a_kind_range, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[3:0] <= sqllex_pkg::KIND_HEX,
    "kind out of range")
  `ASSERT_CLK(a_no_result_idle, clk_i, rst_ni,
    s_fire && decided_q && !first |-> !emit, "result without open candidate")
  `ASSERT_CLK(a_emit_closes, clk_i, rst_ni,
    s_fire && emit |=> decided_q && mode_q == sqllex_pkg::MODE_IDLE && m_valid_q,
    "decision did not close candidate")
  `ASSERT_ALWAYS(a_cnt_bound, clk_i, !rst_ni || cnt_q <= CntMax, "token count beyond limit")

endmodule

/* tb/sql_literal_tokenizer_top_tb.sv */
// Self-checking stream testbench for the SQL literal tokenizer.
`timescale 1ns / 1ps

module sql_literal_tokenizer_top_tb;

  localparam int unsigned RandomItems = 1800;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;

  localparam string Digits  = "0123456789";
  localparam string HexSet  = "0123456789abcdefABCDEF";
  localparam string Letters = "abcdefghijklmnopqrstuvwxyz";
  localparam string Blanks  = " \011\012\013\014\015";
  localparam string NumEnds = " \011\012\013\014\015,)(;";
  localparam string Tricky  = ".E+-'\\NBX0 ,;";

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic                        found;
    sqllex_pkg::kind_e           kind;
    logic                        offs;
    logic [sqllex_pkg::LenW-1:0] len;
  } lit_result_t;

  // Literal classifier mirror and queue of pending classifications
  class literal_checker;
    lit_result_t       expected_tokens[$];
    sqllex_pkg::mode_e mode;
    logic              sgn;
    logic              dec;
    logic              expo;
    logic              done;
    logic              pfx;
    logic [7:0]        prev;
    int unsigned       cnt;
    lit_result_t       res;
    int unsigned       live_items;
    int unsigned       errors;
    int unsigned       reports;

    function new();
      mode       = sqllex_pkg::MODE_IDLE;
      sgn        = 1'b0;
      dec        = 1'b0;
      expo       = 1'b0;
      done       = 1'b1;
      pfx        = 1'b0;
      prev       = '0;
      cnt        = 0;
      live_items = 0;
      errors     = 0;
      reports    = 0;
    endfunction

    function bit blank(logic [7:0] c);
      return c == sqllex_pkg::ChSpace || (c >= sqllex_pkg::ChTab && c <= sqllex_pkg::ChCr);
    endfunction

    function bit numeral(logic [7:0] c);
      return c >= sqllex_pkg::ChZero && c <= sqllex_pkg::ChNine;
    endfunction

    function bit hex_char(logic [7:0] c);
      return numeral(c) || (c >= sqllex_pkg::ChLowA && c <= sqllex_pkg::ChLowF) ||
             (c >= sqllex_pkg::ChUpA && c <= sqllex_pkg::ChUpF);
    endfunction

    function bit ends_number(logic [7:0] c);
      return blank(c) || c == sqllex_pkg::ChComma || c == sqllex_pkg::ChRParen ||
             c == sqllex_pkg::ChLParen || c == sqllex_pkg::ChSemi;
    endfunction

    function sqllex_pkg::kind_e number_kind();
      if (expo) return sqllex_pkg::KIND_APPROX;
      if (dec) return sgn ? sqllex_pkg::KIND_SDEC : sqllex_pkg::KIND_UDEC;
      return sgn ? sqllex_pkg::KIND_SINT : sqllex_pkg::KIND_UINT;
    endfunction

    // Close the candidate and latch its classification
    function bit settle(logic ok, sqllex_pkg::kind_e k);
      done     = 1'b1;
      mode     = sqllex_pkg::MODE_IDLE;
      res.found = ok;
      res.kind  = ok ? k : sqllex_pkg::KIND_UINT;
      res.offs  = ok ? pfx : 1'b0;
      res.len   = ok ? sqllex_pkg::LenW'(cnt) : '0;
      return 1'b1;
    endfunction

    function bit reject();
      return settle(1'b0, sqllex_pkg::KIND_UINT);
    endfunction

    function bit number_char(logic [7:0] ch, logic last);
      if (ends_number(ch)) begin
        if (prev == sqllex_pkg::ChPeriod) return reject();
        if (expo && !numeral(prev)) return reject();
        return settle(1'b1, number_kind());
      end
      if (ch == sqllex_pkg::ChPeriod) begin
        if (dec) return reject();
        dec = 1'b1;
      end else if (ch == sqllex_pkg::ChExpE) begin
        if (expo || !numeral(prev)) return reject();
        expo = 1'b1;
      end else if (ch == sqllex_pkg::ChPlus || ch == sqllex_pkg::ChMinus) begin
        if (!expo) return reject();
      end else if (!numeral(ch)) begin
        return reject();
      end
      if (cnt >= sqllex_pkg::MaxTokenLength) return reject();
      cnt++;
      prev = ch;
      if (last) begin
        if (ch == sqllex_pkg::ChPeriod) return reject();
        if (expo && !numeral(ch)) return reject();
        return settle(1'b1, number_kind());
      end
      return 1'b0;
    endfunction

    function bit string_char(logic [7:0] ch, logic last);
      if (cnt >= sqllex_pkg::MaxTokenLength) return reject();
      cnt++;
      // an unescaped quote closes the string
      if (ch == sqllex_pkg::ChQuote && prev != sqllex_pkg::ChBslash)
        return settle(1'b1, pfx ? sqllex_pkg::KIND_NATL : sqllex_pkg::KIND_CHAR);
      prev = ch;
      if (last) return reject();
      return 1'b0;
    endfunction

    // Bit or hex string must end on a quote and hold more than the opening one
    function bit close_radix(sqllex_pkg::kind_e k);
      if (prev == sqllex_pkg::ChQuote && cnt > 1) return settle(1'b1, k);
      return reject();
    endfunction

    function bit radix_char(logic [7:0] ch, logic last);
      sqllex_pkg::kind_e k;
      logic              ok;
      k = (mode == sqllex_pkg::MODE_BITS) ? sqllex_pkg::KIND_BIT : sqllex_pkg::KIND_HEX;
      if (blank(ch)) return close_radix(k);
      if (k == sqllex_pkg::KIND_BIT)
        ok = ch == sqllex_pkg::ChZero || ch == sqllex_pkg::ChOne || ch == sqllex_pkg::ChQuote;
      else ok = hex_char(ch) || ch == sqllex_pkg::ChQuote;
      if (!ok) return reject();
      if (cnt >= sqllex_pkg::MaxTokenLength) return reject();
      cnt++;
      prev = ch;
      if (last) return close_radix(k);
      return 1'b0;
    endfunction

    function bit open_token(logic [7:0] ch, logic last);
      mode = sqllex_pkg::MODE_IDLE;
      sgn  = 1'b0;
      dec  = 1'b0;
      expo = 1'b0;
      prev = '0;
      cnt  = 0;
      pfx  = 1'b0;
      done = 1'b0;
      if (ch == sqllex_pkg::ChPlus || ch == sqllex_pkg::ChMinus) begin
        if (last) return reject();
        sgn  = 1'b1;
        cnt  = 1;
        prev = ch;
        mode = sqllex_pkg::MODE_SIGN;
        return 1'b0;
      end
      if (numeral(ch)) begin
        mode = sqllex_pkg::MODE_NUM;
        return number_char(ch, last);
      end
      if (ch == sqllex_pkg::ChQuote) begin
        mode = sqllex_pkg::MODE_STR;
        cnt  = 1;
        prev = ch;
        if (last) return reject();
        return 1'b0;
      end
      if (ch == sqllex_pkg::ChNatl || ch == sqllex_pkg::ChBit || ch == sqllex_pkg::ChHex) begin
        if (last) return reject();
        mode = sqllex_pkg::MODE_PREFIX;
        prev = ch;
        return 1'b0;
      end
      return reject();
    endfunction

    // Advance the scan by one character; 1 when a classification is due
    function bit classify_char(logic [7:0] ch, logic first, logic last);
      if (first) return open_token(ch, last);
      if (done) return 1'b0;
      case (mode)
        sqllex_pkg::MODE_SIGN: begin
          if (!numeral(ch)) return reject();
          mode = sqllex_pkg::MODE_NUM;
          return number_char(ch, last);
        end
        sqllex_pkg::MODE_NUM: return number_char(ch, last);
        sqllex_pkg::MODE_PREFIX: begin
          if (ch != sqllex_pkg::ChQuote) return reject();
          pfx = 1'b1;
          cnt = 1;
          if (prev == sqllex_pkg::ChNatl) mode = sqllex_pkg::MODE_STR;
          else if (prev == sqllex_pkg::ChBit) mode = sqllex_pkg::MODE_BITS;
          else mode = sqllex_pkg::MODE_HEX;
          prev = ch;
          if (last) return reject();
          return 1'b0;
        end
        sqllex_pkg::MODE_STR: return string_char(ch, last);
        sqllex_pkg::MODE_BITS, sqllex_pkg::MODE_HEX: return radix_char(ch, last);
        default: return reject();
      endcase
    endfunction

    function void note_char(logic [7:0] ch, logic first, logic last);
      if (first || !done) live_items++;
      if (classify_char(ch, first, last)) expected_tokens.push_back(res);
    endfunction

    function void check_token(logic [23:0] data, logic user);
      lit_result_t want;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (reports < MaxReports) begin
          reports++;
          $display("%0t: unexpected result found=%0b kind=%0d offs=%0b len=%0d", $time,
                   user, data[3:0], data[4], data[17:5]);
        end
        return;
      end
      want = expected_tokens.pop_front();
      if (user !== want.found || data[3:0] !== want.kind || data[4] !== want.offs ||
          data[17:5] !== want.len || data[23:18] !== '0) begin
        errors++;
        if (reports < MaxReports) begin
          reports++;
          $display("%0t: mismatch exp found=%0b kind=%0d offs=%0b len=%0d", $time,
                   want.found, want.kind, want.offs, want.len);
          $display("%0t:          got found=%0b kind=%0d offs=%0b len=%0d pad=%0h", $time,
                   user, data[3:0], data[4], data[17:5], data[23:18]);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;

  bit          src_pause_on  = 1'b0;
  bit          sink_pause_on = 1'b0;
  int unsigned sink_hold     = 0;
  int unsigned quiet         = 0;

  literal_checker sb = new();

  sql_literal_tokenizer_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin : sink_ctrl
    logic rdy;
    rdy = 1'b1;
    if (sink_hold != 0) begin
      sink_hold--;
      rdy = 1'b0;
    end else if (sink_pause_on && $urandom_range(0, 9) == 0) begin
      sink_hold = $urandom_range(1, 18) - 1;
      rdy = 1'b0;
    end
    m_tready <= rdy;
  end

  // Check results, then record accepted requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) sb.check_token(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_char(s_tdata, s_tuser, s_tlast);
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("sql_literal_tokenizer_top verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [7:0] pick(string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic void add_digits(ref char_q_t q, input int unsigned n);
    repeat (n) q.push_back(pick(Digits));
  endfunction

  function automatic char_q_t build_number(output bit use_last);
    char_q_t q;
    if ($urandom_range(0, 2) == 0)
      q.push_back($urandom_range(0, 1) ? sqllex_pkg::ChPlus : sqllex_pkg::ChMinus);
    add_digits(q, $urandom_range(1, 5));
    if ($urandom_range(0, 4) < 2) begin
      q.push_back(sqllex_pkg::ChPeriod);
      add_digits(q, $urandom_range(0, 4));
    end
    if ($urandom_range(0, 9) < 3) begin
      q.push_back(sqllex_pkg::ChExpE);
      if ($urandom_range(0, 1))
        q.push_back($urandom_range(0, 1) ? sqllex_pkg::ChPlus : sqllex_pkg::ChMinus);
      add_digits(q, $urandom_range(1, 3));
    end
    use_last = $urandom_range(0, 1);
    if (!use_last) q.push_back(pick(NumEnds));
    return q;
  endfunction

  function automatic char_q_t build_string(output bit use_last);
    char_q_t q;
    if ($urandom_range(0, 3) == 0) q.push_back(sqllex_pkg::ChNatl);
    q.push_back(sqllex_pkg::ChQuote);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 4))
        0: q.push_back(pick(Letters));
        1: q.push_back(sqllex_pkg::ChSpace);
        2: begin
          q.push_back(sqllex_pkg::ChBslash);
          q.push_back(sqllex_pkg::ChQuote);
        end
        3: q.push_back(8'($urandom_range(32, 126)));
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    // leave some strings open up to the end of the buffer
    use_last = $urandom_range(0, 6) == 0;
    if (!use_last) q.push_back(sqllex_pkg::ChQuote);
    return q;
  endfunction

  function automatic char_q_t build_radix(output bit use_last);
    char_q_t q;
    bit      bits;
    bits = $urandom_range(0, 1);
    q.push_back(bits ? sqllex_pkg::ChBit : sqllex_pkg::ChHex);
    q.push_back(sqllex_pkg::ChQuote);
    repeat ($urandom_range(0, 8)) q.push_back(bits ? pick("01") : pick(HexSet));
    q.push_back(sqllex_pkg::ChQuote);
    use_last = $urandom_range(0, 1);
    if (!use_last) q.push_back(pick(Blanks));
    return q;
  endfunction

  // Replace, drop or insert one character
  function automatic void mutate(ref char_q_t q);
    int unsigned pos;
    logic [7:0]  odd;
    pos = $urandom_range(0, q.size() - 1);
    odd = $urandom_range(0, 1) ? pick(Tricky) : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: q[pos] = odd;
      1: if (q.size() > 1) q.delete(pos);
      default: q.insert(pos, odd);
    endcase
  endfunction

  // Offer one character request and hold it until accepted
  task automatic push_char(logic [7:0] ch, logic first, logic last);
    int unsigned gap;
    gap = 0;
    if (src_pause_on && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 18);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_token(char_q_t q, bit use_last);
    foreach (q[i]) push_char(q[i], i == 0, use_last && i == q.size() - 1);
  endtask

  task automatic send_text(string s, bit use_last);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_token(q, use_last);
  endtask

  initial begin
    int unsigned goal;
    int unsigned tokens;
    int unsigned r;
    char_q_t     q;
    bit          use_last;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every kind, failure rules, and stray characters
    push_char(8'h00, 1'b0, 1'b1);
    send_text("0", 1'b1);
    send_text("-5,", 1'b0);
    send_text("12.5 ", 1'b0);
    send_text("+3.25;", 1'b0);
    send_text("1E+9)", 1'b0);
    send_text("'a\\'b'", 1'b0);
    send_text("N'x'", 1'b0);
    send_text("B'01'\011", 1'b0);
    send_text("X'fF'", 1'b1);
    send_text("5.", 1'b1);
    send_text("7.(", 1'b0);
    send_text("-", 1'b1);
    send_text("'ab\\'", 1'b1);
    send_text("12", 1'b0);
    send_text("N", 1'b1);
    push_char(8'hFF, 1'b1, 1'b0);

    // Random: mostly well-formed literals, some mutated, cut short or noise
    goal   = sb.live_items + RandomItems;
    tokens = 0;
    while (sb.live_items < goal) begin
      if (tokens % 40 == 0) begin
        if (sb.live_items + RandomItems / 6 >= goal) {src_pause_on, sink_pause_on} = 2'b00;
        else {src_pause_on, sink_pause_on} = 2'($urandom_range(0, 3));
      end
      tokens++;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6))
          push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 1));
      end else begin
        if (r < 40) q = build_number(use_last);
        else if (r < 70) q = build_string(use_last);
        else q = build_radix(use_last);
        if ($urandom_range(0, 4) == 0) mutate(q);
        // abandon some candidates mid-way; the next start drops them
        if ($urandom_range(0, 12) == 0) begin
          q = q[0:$urandom_range(0, q.size() - 1)];
          use_last = 1'b0;
        end
        send_token(q, use_last);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3))
            push_char(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1));
        end
      end
    end

    // Drain outstanding classifications
    {src_pause_on, sink_pause_on} = 2'b00;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("sql_literal_tokenizer_top verification clean");
    end else begin
      $display("sql_literal_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule
